@@ src/tach_period_to_led_bar_color_top_assert.svh @@
// Assertion macros for the tachometer bar-graph block.
`ifndef TACH_PERIOD_TO_LED_BAR_COLOR_TOP_ASSERT_SVH
`define TACH_PERIOD_TO_LED_BAR_COLOR_TOP_ASSERT_SVH

// Check that cond holds in the same cycle as trig.
`define TACHBAR_ASSERT_SAME(label, clock, reset, trig, cond) \
  label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
    else $error("tachbar check failed");

// Check that cond holds in the cycle after trig.
`define TACHBAR_ASSERT_NEXT(label, clock, reset, trig, cond) \
  label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
    else $error("tachbar check failed");

`endif

@@ src/tachbar_pkg.sv @@
// Types, constants and helper functions of the tachometer bar-graph block.
package tachbar_pkg;

  localparam int TIME_W     = 32;
  localparam int OVF_W      = 32;
  localparam int MODE_W     = 2;
  localparam int COUNT_W    = 8;
  localparam int TICK_W     = 20;
  localparam int BRIGHT_W   = 7;
  localparam int BRATE_W    = 8;
  localparam int SCHEME_W   = 1;
  localparam int BARS_W     = 16;
  localparam int DUTY_W     = 8;
  localparam int BTICK_W    = 8;
  localparam int REG_IDX_W  = 2;
  localparam int REG_DATA_W = 20;

  localparam int TOP_W      = 26;
  localparam int DEN_W      = TIME_W + 8;
  localparam int DIV_CNT_W  = $clog2(TOP_W);
  localparam int PROD_W     = BRIGHT_W + BARS_W;
  localparam int R100_W     = 28;
  localparam int R7_W       = 16;

  localparam logic [MODE_W-1:0] MODE_CAPTURE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OVERFLOW = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BLINK    = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_TICK_RATE     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BRIGHTNESS    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TOGGLE_PERIOD = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SCHEME        = 2'd3;

  localparam logic [TICK_W-1:0]   TICK_RATE_RST     = 20'd125000;
  localparam logic [BRIGHT_W-1:0] BRIGHTNESS_RST    = 7'd100;
  localparam logic [BRATE_W-1:0]  TOGGLE_PERIOD_RST = 8'd10;
  localparam logic [BARS_W-1:0]   BARS_RST          = 16'd15;

  localparam int RPM_SCALE    = 60;
  localparam int BAR_RPM      = 140;
  localparam int BARS_MAX     = 65535;
  localparam int BLUE_MAX     = 5;
  localparam int GREEN_MAX    = 10;
  localparam int BLEND_MAX    = 25;
  localparam int BLEND_STEP   = 17;
  localparam int BLEND_TOP    = 16;
  localparam int FULL_SCALE   = 255;
  localparam int PCT          = 100;
  localparam int SAT_LIMIT    = 256 * PCT;
  localparam int RECIP_100    = 5243;
  localparam int RECIP_100_SH = 19;
  localparam int RECIP_7      = 293;
  localparam int RECIP_7_SH   = 11;
  localparam int LIT_SAT_BARS = 224;
  localparam int RATE_WRAP    = 256;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SETUP,
    S_DIV,
    S_POST,
    S_MUL,
    S_DUTY
  } state_t;

  // x * brightness already formed; return min(255, x / 100).
  function automatic logic [DUTY_W-1:0] div100_sat(input logic [PROD_W-1:0] x);
    logic [R100_W-1:0] t;
    logic [DUTY_W-1:0] q;
    t = R100_W'(x[14:0]) * R100_W'(RECIP_100);
    if (x >= PROD_W'(SAT_LIMIT)) begin
      q = DUTY_W'(FULL_SCALE);
    end else begin
      q = t[RECIP_100_SH +: DUTY_W];
    end
    return q;
  endfunction

  // bars + bars / 7, saturated at 255.
  function automatic logic [DUTY_W-1:0] lit_total(input logic [BARS_W-1:0] bars);
    logic [R7_W-1:0] t;
    logic [DUTY_W-1:0] q;
    t = R7_W'(bars[DUTY_W-1:0]) * R7_W'(RECIP_7);
    if (bars >= BARS_W'(LIT_SAT_BARS)) begin
      q = DUTY_W'(FULL_SCALE);
    end else begin
      q = bars[DUTY_W-1:0] + DUTY_W'(t[R7_W-1:RECIP_7_SH]);
    end
    return q;
  endfunction

endpackage

@@ src/tachbar_if.sv @@
// Valid/ready request and result channels of the tachometer bar-graph block.
interface tachbar_in_if;
  import tachbar_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [COUNT_W-1:0] capture_count;

  modport source (output valid, output mode, output capture_count, input ready);
  modport sink (input valid, input mode, input capture_count, output ready);
endinterface

interface tachbar_out_if;
  import tachbar_pkg::*;

  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] lit_leds;
  logic [DUTY_W-1:0] red_duty;
  logic [DUTY_W-1:0] green_duty;
  logic [DUTY_W-1:0] blue_duty;
  logic              blink_active;
  logic              display_on;
  logic              display_refresh;

  modport source (
    output valid, output lit_leds, output red_duty, output green_duty,
    output blue_duty, output blink_active, output display_on,
    output display_refresh, input ready
  );
  modport sink (
    input valid, input lit_leds, input red_duty, input green_duty,
    input blue_duty, input blink_active, input display_on,
    input display_refresh, output ready
  );
endinterface

@@ src/tach_period_to_led_bar_color_top.sv @@
// Tachometer bar-graph controller: each request is a tach capture, a capture
// timer overflow or a blink tick, and each gives one result with the LED
// count, RGB duty values, blink flag and display enable. A capture runs the
// period through a shared 26-step restoring divider (bars = 60 * tick_rate /
// (140 * period)), then its post, multiply and duty steps; the input is ready
// again in the same cycle as its result becomes valid. A blink tick while the
// overspeed blink is on uses the same divider for its modulo and takes the same
// path; every other request skips the divider, going from its load step to the
// multiply and duty steps. One request is in work at a time; a result that is
// not taken holds the block in its last step, and a finished result waits in
// the output register while the next request is taken.
`include "tach_period_to_led_bar_color_top_assert.svh"

module tach_period_to_led_bar_color_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [tachbar_pkg::REG_IDX_W-1:0]   wr_index,
  input  logic [tachbar_pkg::REG_DATA_W-1:0]  wr_data,
  tachbar_in_if.sink                          item,
  tachbar_out_if.source                       result
);
  import tachbar_pkg::*;

  state_t state;
  state_t state_next;

  logic [TICK_W-1:0]   tick_rate;
  logic [BRIGHT_W-1:0] brightness;
  logic [BRATE_W-1:0]  toggle_period;
  logic                colour_scheme;

  logic [TIME_W-1:0]   previous_time;
  logic [OVF_W-1:0]    overflow_count;
  logic [BTICK_W-1:0]  blink_ticks;
  logic [BARS_W-1:0]   bars_shown;
  logic                blink_flag;
  logic                enable_state;

  logic [MODE_W-1:0]   mode_r;
  logic [COUNT_W-1:0]  count_r;
  logic [TIME_W-1:0]   period;
  logic [TOP_W-1:0]    div_num;
  logic [DEN_W-1:0]    div_rem;
  logic [DEN_W-1:0]    div_den;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [PROD_W-1:0]   prod;

  logic                accept;
  logic                out_load;
  logic [TIME_W-1:0]   now;
  logic [DEN_W:0]      rem_shift;
  logic                rem_fit;
  logic [BARS_W-1:0]   bars_next;
  logic [3:0]          red_steps;
  logic [BARS_W-1:0]   mul_arg;
  logic [DUTY_W-1:0]   full_duty;
  logic [DUTY_W-1:0]   main_duty;
  logic [DUTY_W-1:0]   grn_duty;
  logic [DUTY_W-1:0]   red_sel;
  logic [DUTY_W-1:0]   grn_sel;
  logic [DUTY_W-1:0]   blu_sel;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item.valid) state_next = S_LOAD;
      end
      S_LOAD: begin
        priority if (mode_r == MODE_CAPTURE) state_next = S_SETUP;
        else if (mode_r == MODE_BLINK && blink_flag) state_next = S_SETUP;
        else state_next = S_MUL;
      end
      S_SETUP: state_next = S_DIV;
      S_DIV: begin
        if (div_cnt == '0) state_next = S_POST;
      end
      S_POST: state_next = S_MUL;
      S_MUL: state_next = S_DUTY;
      S_DUTY: begin
        if (!result.valid || result.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake and control outputs.
  always_comb begin
    item.ready = (state == S_IDLE);
    accept     = item.valid && (state == S_IDLE);
    out_load   = (state == S_DUTY) && (!result.valid || result.ready);
  end

  // Datapath helpers.
  always_comb begin
    now       = TIME_W'({overflow_count, count_r});
    rem_shift = {div_rem, div_num[TOP_W-1]};
    rem_fit   = rem_shift >= {1'b0, div_den};
    bars_next = (div_num > TOP_W'(BARS_MAX)) ? BARS_W'(BARS_MAX) : div_num[BARS_W-1:0];
    red_steps = 4'(bars_shown - BARS_W'(GREEN_MAX));
    if (bars_shown <= BARS_W'(BLEND_MAX)) begin
      mul_arg = BARS_W'(red_steps) * BARS_W'(BLEND_STEP);
    end else begin
      mul_arg = bars_shown - BARS_W'(BLEND_MAX);
    end
    full_duty = div100_sat(PROD_W'(brightness) * PROD_W'(FULL_SCALE));
    main_duty = div100_sat(prod);
    grn_duty  = div100_sat(PROD_W'(brightness) * PROD_W'(BLEND_STEP * BLEND_TOP) - prod);
    red_sel   = '0;
    grn_sel   = '0;
    blu_sel   = '0;
    priority if (colour_scheme) begin
      red_sel = full_duty;
      blu_sel = full_duty;
    end else if (bars_shown <= BARS_W'(BLUE_MAX)) begin
      blu_sel = full_duty;
    end else if (bars_shown <= BARS_W'(GREEN_MAX)) begin
      grn_sel = full_duty;
    end else if (bars_shown <= BARS_W'(BLEND_MAX)) begin
      red_sel = main_duty;
      grn_sel = grn_duty;
    end else begin
      red_sel = full_duty;
      blu_sel = main_duty;
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      result.valid   <= 1'b0;
      tick_rate      <= TICK_RATE_RST;
      brightness     <= BRIGHTNESS_RST;
      toggle_period  <= TOGGLE_PERIOD_RST;
      colour_scheme  <= 1'b0;
      previous_time  <= '0;
      overflow_count <= '0;
      blink_ticks    <= '0;
      bars_shown     <= BARS_RST;
      blink_flag     <= 1'b0;
      enable_state   <= 1'b1;
      div_cnt        <= '0;
    end else begin
      state <= state_next;
      if (out_load) result.valid <= 1'b1;
      else if (result.ready) result.valid <= 1'b0;
      if (wr_en) begin
        unique case (wr_index)
          REG_TICK_RATE:     tick_rate     <= wr_data[TICK_W-1:0];
          REG_BRIGHTNESS:    brightness    <= wr_data[BRIGHT_W-1:0];
          REG_TOGGLE_PERIOD: toggle_period <= wr_data[BRATE_W-1:0];
          REG_SCHEME:        colour_scheme <= wr_data[0];
          default: ;
        endcase
      end
      unique case (state)
        S_LOAD: begin
          unique case (mode_r)
            MODE_CAPTURE: previous_time <= now;
            MODE_OVERFLOW: overflow_count <= overflow_count + OVF_W'(1);
            MODE_BLINK: begin
              blink_ticks <= blink_ticks + BTICK_W'(1);
              if (!blink_flag) enable_state <= 1'b1;
            end
            default: ;
          endcase
        end
        S_SETUP: div_cnt <= DIV_CNT_W'(TOP_W - 1);
        S_DIV: div_cnt <= div_cnt - DIV_CNT_W'(1);
        S_POST: begin
          if (mode_r == MODE_CAPTURE) begin
            bars_shown <= bars_next;
            if (colour_scheme) begin
              if (bars_next <= BARS_W'(BLEND_MAX)) blink_flag <= 1'b0;
            end else begin
              blink_flag <= bars_next > BARS_W'(BLEND_MAX);
            end
          end else if (div_rem == '0) begin
            enable_state <= !enable_state;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= item.mode;
      count_r <= item.capture_count;
    end
    if (state == S_LOAD) period <= now - previous_time;
    if (state == S_SETUP) begin
      div_rem <= '0;
      if (mode_r == MODE_CAPTURE) begin
        div_num <= TOP_W'(tick_rate) * TOP_W'(RPM_SCALE);
        if (period == '0) div_den <= DEN_W'(BAR_RPM);
        else div_den <= DEN_W'(period) * DEN_W'(BAR_RPM);
      end else begin
        div_num <= TOP_W'(blink_ticks);
        if (toggle_period == '0) div_den <= DEN_W'(RATE_WRAP);
        else div_den <= DEN_W'(toggle_period);
      end
    end
    if (state == S_DIV) begin
      if (rem_fit) div_rem <= DEN_W'(rem_shift - {1'b0, div_den});
      else div_rem <= rem_shift[DEN_W-1:0];
      div_num <= {div_num[TOP_W-2:0], rem_fit};
    end
    if (state == S_MUL) prod <= PROD_W'(brightness) * PROD_W'(mul_arg);
    if (out_load) begin
      result.lit_leds        <= lit_total(bars_shown);
      result.red_duty        <= red_sel;
      result.green_duty      <= grn_sel;
      result.blue_duty       <= blu_sel;
      result.blink_active    <= blink_flag;
      result.display_on      <= enable_state;
      result.display_refresh <= (mode_r == MODE_CAPTURE);
    end
  end

  `TACHBAR_ASSERT_NEXT(a_busy_after_accept, clk, rst, item.valid && item.ready, !item.ready)
  `TACHBAR_ASSERT_SAME(a_div_rem_below_den, clk, rst, state == S_DIV, div_rem < div_den)
  `TACHBAR_ASSERT_SAME(a_blink_needs_overspeed, clk, rst, blink_flag,
                       bars_shown > BARS_W'(BLEND_MAX))

endmodule
